// ===== rtl/cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants for the cell balancing scheduler.
// ----------------------------------------------------------------------------
package cbs_pkg;

	localparam int MAX_CELLS = 120;
	localparam int VW = 15;
	localparam logic [VW-1:0] VOLT_NONE = 15'h7FFF;
	localparam logic [VW-1:0] BUDGET_MAX = 15'h7FFF;

	// configuration register indexes
	localparam logic [2:0] REG_RESTART = 3'd0;
	localparam logic [2:0] REG_GAIN    = 3'd1;
	localparam logic [2:0] REG_OFFSET  = 3'd2;
	localparam logic [2:0] REG_PAUSE   = 3'd3;
	localparam logic [2:0] REG_FLOOR   = 3'd4;

	// input commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic          wr_en;
		logic [VW-1:0] wr_v;
		logic [VW-1:0] floor_mv;
		logic [VW-1:0] minv;
		logic [7:0]    offset;
		logic [7:0]    gain;
		logic          do_budget;
		logic          do_mark;
		logic          mark_par;
		logic          dec;
		logic          clr_mask;
	} cbs_ctl_t;

endpackage

// ===== rtl/cell_balancing_scheduler.sv =====
// ----------------------------------------------------------------------------
// cell_balancing_scheduler
// Passive balancer: a row of cells holding voltages and budgets, driven by
// a small sequencer that finds the minimum and issues bleed masks per tick.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, command..elapsed_ms    | request in
//  out     | out_valid/out_ready, mask_low..paused     | result out
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | register write
//
// write item, idle tick, fault tick or pause tick: DECIDE, FIN; bleeding
// tick: DECIDE, MARK, DONE, FIN; session start: DECIDE, MIN, BUDGET, MARK,
// FIN, staying in MIN while the minimum passes down the cell chain.
// one item at a time; the next request is taken once the result is in the
// output register, while that result waits for out_ready.
// reset clears voltages, budgets, masks and all control state at once.
module cell_balancing_scheduler #(
	parameter int CELL_COUNT = 120
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [6:0]  cell_index,
	input  logic [14:0] cell_mv,
	input  logic        fatal_fault,
	input  logic [15:0] elapsed_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] mask_low,
	output logic [55:0] mask_high,
	output logic        session_on,
	output logic        paused,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import cbs_pkg::*;

	localparam int CW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_MIN    = 3'd2;
	localparam logic [2:0] ST_BUDGET = 3'd3;
	localparam logic [2:0] ST_MARK   = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [2:0]   st_q;
	logic [31:0]  restart_q;
	logic [7:0]   gain_q;
	logic [7:0]   offset_q;
	logic [3:0]   pint_q;
	logic [VW-1:0] floor_q;
	logic         cmd_q;
	logic         fault_q;
	logic         active_q;
	logic         even_q;
	logic         start_q;
	logic         paused_q;
	logic [3:0]   pcnt_q;
	logic [31:0]  age_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] wr_v_q;
	logic [6:0]   wr_idx_q;
	logic         out_valid_q;
	logic [63:0]  mlow_q;
	logic [55:0]  mhigh_q;
	logic         oact_q;
	logic         opaused_q;

	cbs_ctl_t     ctl;
	logic [VW-1:0] min_chain [CELL_COUNT+1];
	logic [CELL_COUNT-1:0] bnz;
	logic [CELL_COUNT-1:0] mbits;
	logic [CELL_COUNT-1:0] even_bits;
	logic [MAX_CELLS-1:0] mask_full;
	logic         any_even;
	logic         any_odd;
	logic         any_cur;
	logic         mark_par;
	logic [32:0]  age_sum;
	logic         in_acc;
	logic         take_pause;
	logic         out_load;

	assign in_acc = in_valid && in_ready;
	assign in_ready = (st_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign age_sum = {1'b0, age_q} + 33'(elapsed_ms);
	assign out_load = (st_q == ST_FIN) && (!out_valid_q || out_ready);

	// parity selection with fallback
	assign any_even = |(bnz & even_bits);
	assign any_odd = |(bnz & ~even_bits);
	assign any_cur = even_q ? any_even : any_odd;
	assign mark_par = any_cur ? even_q : ~even_q;
	assign take_pause = (pint_q != 4'd0) && (pcnt_q == pint_q);

	// broadcast control
	always_comb begin
		ctl = '0;
		ctl.wr_en = (st_q == ST_DECIDE) && (cmd_q == CMD_WRITE);
		ctl.wr_v = wr_v_q;
		ctl.floor_mv = floor_q;
		ctl.minv = min_chain[CELL_COUNT];
		ctl.offset = offset_q;
		ctl.gain = gain_q;
		ctl.do_budget = (st_q == ST_BUDGET);
		ctl.do_mark = (st_q == ST_MARK);
		ctl.mark_par = mark_par;
		ctl.dec = ~start_q;
		ctl.clr_mask = (st_q == ST_DECIDE) && (cmd_q == CMD_TICK) && active_q &&
			(fault_q || take_pause);
	end

	// row of cells
	assign min_chain[0] = VOLT_NONE;
	for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
		assign even_bits[i] = ((i % 2) == 0);
		cbs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_sel   (wr_idx_q == 7'(i)),
			.is_even  (even_bits[i]),
			.min_in   (min_chain[i]),
			.min_out  (min_chain[i+1]),
			.budget_nz(bnz[i]),
			.mask_bit (mbits[i])
		);
	end
	assign mask_full = MAX_CELLS'(mbits);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= 32'd30000;
			gain_q <= 8'd50;
			offset_q <= 8'd2;
			pint_q <= 4'd9;
			floor_q <= 15'd2500;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RESTART: restart_q <= cfg_data;
				REG_GAIN:    gain_q <= cfg_data[7:0];
				REG_OFFSET:  offset_q <= cfg_data[7:0];
				REG_PAUSE:   pint_q <= cfg_data[3:0];
				REG_FLOOR:   floor_q <= cfg_data[VW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cmd_q <= CMD_WRITE;
			fault_q <= 1'b0;
			active_q <= 1'b0;
			even_q <= 1'b0;
			start_q <= 1'b0;
			paused_q <= 1'b0;
			pcnt_q <= '0;
			age_q <= '0;
			cnt_q <= '0;
			wr_v_q <= '0;
			wr_idx_q <= '0;
			out_valid_q <= 1'b0;
			mlow_q <= '0;
			mhigh_q <= '0;
			oact_q <= 1'b0;
			opaused_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						cmd_q <= command;
						fault_q <= fatal_fault;
						wr_v_q <= cell_mv;
						wr_idx_q <= cell_index;
						paused_q <= 1'b0;
						start_q <= 1'b0;
						if (command == CMD_TICK) begin
							age_q <= age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
						end
						st_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (cmd_q == CMD_WRITE) begin
						st_q <= ST_FIN;
					end else if (!active_q) begin
						if (age_q >= restart_q && !fault_q) begin
							cnt_q <= '0;
							start_q <= 1'b1;
							st_q <= ST_MIN;
						end else begin
							st_q <= ST_FIN;
						end
					end else if (fault_q) begin
						active_q <= 1'b0;
						age_q <= '0;
						st_q <= ST_FIN;
					end else begin
						if (take_pause) begin
							pcnt_q <= '0;
							paused_q <= 1'b1;
							st_q <= ST_FIN;
						end else begin
							if (pint_q != 4'd0) begin
								pcnt_q <= pcnt_q + 4'd1;
							end
							st_q <= ST_MARK;
						end
					end
				end
				ST_MIN: begin
					// minimum ripples one cell per cycle
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(CELL_COUNT - 1)) begin
						st_q <= ST_BUDGET;
					end
				end
				ST_BUDGET: begin
					st_q <= ST_MARK;
				end
				ST_MARK: begin
					if (start_q) begin
						even_q <= mark_par;
						active_q <= 1'b1;
						age_q <= '0;
						st_q <= ST_FIN;
					end else begin
						even_q <= ~mark_par;
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (bnz == '0 && mbits == '0) begin
						active_q <= 1'b0;
						age_q <= '0;
					end
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						mlow_q <= mask_full[63:0];
						mhigh_q <= mask_full[MAX_CELLS-1:64];
						oact_q <= active_q;
						opaused_q <= paused_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign mask_low = mlow_q;
	assign mask_high = mhigh_q;
	assign session_on = oact_q;
	assign paused = opaused_q;

endmodule

// ===== rtl/cbs_cell.sv =====
// ----------------------------------------------------------------------------
// cbs_cell
// One battery cell: voltage, budget and request bit, plus one link of the
// running minimum chain that passes to the next cell every cycle.
// ----------------------------------------------------------------------------
module cbs_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cbs_pkg::cbs_ctl_t                ctl,
	input  logic                             wr_sel,
	input  logic                             is_even,
	input  logic [cbs_pkg::VW-1:0]           min_in,
	output logic [cbs_pkg::VW-1:0]           min_out,
	output logic                             budget_nz,
	output logic                             mask_bit
);
	import cbs_pkg::*;

	logic [VW-1:0]  volt_q;
	logic [VW-1:0]  budget_q;
	logic [VW-1:0]  min_q;
	logic           mask_q;
	logic [16:0]    diff;
	logic [22:0]    prod;
	logic [VW-1:0]  budget_new;
	logic           hit;

	// budget from difference to minimum, saturated
	always_comb begin
		diff = {2'b00, volt_q} - {2'b00, ctl.minv} - {9'd0, ctl.offset};
		prod = diff[VW-1:0] * ctl.gain;
		if (diff[16] || diff == 17'd0) begin
			budget_new = '0;
		end else if (prod > 23'(BUDGET_MAX)) begin
			budget_new = BUDGET_MAX;
		end else begin
			budget_new = prod[VW-1:0];
		end
	end

	assign hit = (budget_q != '0) && (is_even == ctl.mark_par);

	// voltage store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_q <= '0;
		end else if (ctl.wr_en && wr_sel) begin
			volt_q <= ctl.wr_v;
		end
	end

	// running minimum link
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= VOLT_NONE;
		end else if (volt_q > ctl.floor_mv && volt_q < min_in) begin
			min_q <= volt_q;
		end else begin
			min_q <= min_in;
		end
	end

	// budget and request bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
			mask_q <= 1'b0;
		end else if (ctl.do_budget) begin
			budget_q <= budget_new;
		end else if (ctl.do_mark) begin
			mask_q <= hit;
			if (hit) begin
				budget_q <= budget_q - VW'(ctl.dec);
			end
		end else if (ctl.clr_mask) begin
			mask_q <= 1'b0;
		end
	end

	assign min_out = min_q;
	assign budget_nz = (budget_q != '0);
	assign mask_bit = mask_q;

endmodule

// ===== rtl/cbs_checker.sv =====
// ----------------------------------------------------------------------------
// cbs_checker
// Port-level checks for the cell balancing scheduler.
// ----------------------------------------------------------------------------
module cbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] mask_low,
	input logic [55:0] mask_high,
	input logic        session_on,
	input logic        paused
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mask_low) && $stable(mask_high))
		else $error("result changed while stalled");

	// a pause only happens in an active session
	a_pause_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && paused |-> session_on)
		else $error("pause outside session");

	// pause tick bleeds nothing
	a_pause_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && paused |-> mask_low == 64'd0 && mask_high == 56'd0)
		else $error("mask set on pause");

	// idle never bleeds
	a_idle_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !session_on |-> mask_low == 64'd0 && mask_high == 56'd0)
		else $error("mask set while idle");

endmodule

bind cell_balancing_scheduler cbs_checker u_cbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.mask_low  (mask_low),
	.mask_high (mask_high),
	.session_on(session_on),
	.paused    (paused)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cell balancing scheduler: voltage writes and
// ticks go in over valid/ready, a behavioral balancer model predicts every
// mask, and each result is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
class balance_board;
	int unsigned  restart_ms;
	int unsigned  gain;
	int unsigned  offset;
	int unsigned  pause_int;
	int unsigned  floor_mv;
	bit           active;
	int unsigned  age_ms;
	bit [14:0]    volts [120];
	bit [15:0]    budget [120];
	bit [119:0]   mask;
	bit           even_par;
	int unsigned  pause_cnt;
	bit [121:0]   pending [$];
	int           errors;

	function void clear();
		restart_ms = 30000; gain = 50; offset = 2; pause_int = 9; floor_mv = 2500;
		active = 0; age_ms = 0; mask = '0; even_par = 0; pause_cnt = 0;
		foreach (volts[c]) begin
			volts[c] = 0;
			budget[c] = 0;
		end
		errors = 0;
	endfunction

	function void set_reg(bit [2:0] idx, bit [31:0] val);
		case (idx)
			cbs_pkg::REG_RESTART: restart_ms = val;
			cbs_pkg::REG_GAIN:    gain = val[7:0];
			cbs_pkg::REG_OFFSET:  offset = val[7:0];
			cbs_pkg::REG_PAUSE:   pause_int = val[3:0];
			cbs_pkg::REG_FLOOR:   floor_mv = val[14:0];
			default: ;
		endcase
	endfunction

	function bit mark_cells(bit [15:0] dec);
		bit any;
		any = 0;
		mask = '0;
		for (int c = 0; c < 120; c++) begin
			if (budget[c] > 0 && ((c % 2) == 0) == even_par) begin
				budget[c] = budget[c] - dec;
				mask[c] = 1;
				any = 1;
			end
		end
		return any;
	endfunction

	function void bleed(bit [15:0] dec);
		if (!mark_cells(dec)) begin
			even_par = !even_par;
			void'(mark_cells(dec));
		end
	endfunction

	function void open_session();
		int minv;
		int diff;
		int b;
		minv = 'h7FFF;
		for (int c = 0; c < 120; c++)
			if (volts[c] > floor_mv && volts[c] < minv) minv = volts[c];
		for (int c = 0; c < 120; c++) begin
			diff = int'(volts[c]) - minv - int'(offset);
			b = 0;
			if (diff > 0) begin
				b = diff * gain;
				if (b > 'h7FFF) b = 'h7FFF;
			end
			budget[c] = b;
		end
		bleed(0);
	endfunction

	// note one accepted request and queue its expected result
	function void note_request(bit cmd, bit [6:0] idx, bit [14:0] v, bit flt, bit [15:0] el);
		bit pz;
		bit done;
		pz = 0;
		if (cmd == cbs_pkg::CMD_WRITE) begin
			if (idx < 120) volts[idx] = v;
		end else begin
			age_ms = (age_ms > 32'hFFFF_FFFF - el) ? 32'hFFFF_FFFF : age_ms + el;
			if (!active) begin
				if (age_ms >= restart_ms && !flt) begin
					open_session();
					active = 1;
					age_ms = 0;
				end
			end else if (flt) begin
				mask = '0;
				active = 0;
				age_ms = 0;
			end else begin
				bit tp;
				tp = 0;
				if (pause_int > 0) begin
					tp = pause_cnt == pause_int;
					pause_cnt = (pause_cnt + 1) & 15;
				end
				if (tp) begin
					mask = '0;
					pause_cnt = 0;
					pz = 1;
				end else begin
					bleed(1);
					even_par = !even_par;
					done = (mask == 0);
					foreach (budget[c]) if (budget[c] != 0) done = 0;
					if (done) begin
						active = 0;
						age_ms = 0;
					end
				end
			end
		end
		pending.push_back({pz, active, mask});
	endfunction

	// compare one result with the oldest expectation
	function void check_result(bit [63:0] lo, bit [55:0] hi, bit act, bit pz);
		bit [121:0] exp_r;
		bit [121:0] got;
		got = {pz, act, hi, lo};
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result %h", got);
			return;
		end
		exp_r = pending.pop_front();
		if (exp_r !== got) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: paused %0b/%0b active %0b/%0b mask %h/%h",
					exp_r[121], pz, exp_r[120], act, exp_r[119:0], got[119:0]);
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cbs_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0, in_ready;
	logic        command = 0;
	logic [6:0]  cell_index = 0;
	logic [14:0] cell_mv = 0;
	logic        fatal_fault = 0;
	logic [15:0] elapsed_ms = 0;
	logic        out_valid, out_ready = 0;
	logic [63:0] mask_low;
	logic [55:0] mask_high;
	logic        session_on, paused;
	logic        cfg_valid = 0, cfg_ready;
	logic [2:0]  cfg_index = 0;
	logic [31:0] cfg_data = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	balance_board board;

	cell_balancing_scheduler dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// receiver with random stalls, checking each accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(mask_low, mask_high, session_on, paused);
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// valid stays high after an accept until the next request or an idle gap
	task automatic send_request(bit cmd, bit [6:0] idx, bit [14:0] v, bit flt, bit [15:0] el);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1;
		command <= cmd;
		cell_index <= idx;
		cell_mv <= v;
		fatal_fault <= flt;
		elapsed_ms <= el;
		do @(posedge clk); while (!in_ready);
		board.note_request(cmd, idx, v, flt, el);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(bit [2:0] idx, bit [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic tick(bit flt, bit [15:0] el);
		send_request(CMD_TICK, $urandom, $urandom, flt, el);
	endtask

	task automatic write_cell(bit [6:0] idx, bit [14:0] v);
		send_request(CMD_WRITE, idx, v, $urandom, $urandom);
	endtask

	// one session: fresh voltages near a base, then mostly clean ticks
	task automatic run_session(int n_ticks);
		int base;
		base = $urandom_range(2400, 4200);
		repeat ($urandom_range(2, 8))
			write_cell($urandom_range(119), base + $urandom_range(0, 60));
		if ($urandom_range(9) == 0) write_cell($urandom_range(127), $urandom);
		for (int k = 0; k < n_ticks; k++)
			tick($urandom_range(29) == 0, ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 40));
	endtask

	initial begin
		#50000000;
		$display("FAIL cell_balancing_scheduler");
		$finish;
	end

	initial begin
		board = new();
		board.clear();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// small budgets keep sessions short
		write_reg(REG_RESTART, 0);
		write_reg(REG_GAIN, 1);
		write_reg(REG_OFFSET, 0);
		write_reg(REG_PAUSE, 3);
		write_reg(REG_FLOOR, 2500);

		// directed: extremes, out-of-range index, no valid cell, faults
		tick(0, 16'hFFFF);
		tick(0, 0);
		write_cell(0, 15'h7FFF);
		write_cell(119, 0);
		write_cell(127, 15'h1234);
		write_cell(1, 2501);
		write_cell(2, 2504);
		write_cell(3, 2500);
		tick(1, 5);
		tick(0, 1);
		tick(0, 0);
		tick(1, 0);
		tick(0, 1);
		repeat (6) tick(0, 0);
		write_cell(0, 0);
		repeat (4) tick(0, 0);
		drain();

		// random phases with several register settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				3: begin send_idle_pct = 34; recv_stall_pct = 34; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			write_reg(REG_RESTART, (ph == 4) ? 32'hFFFF_FFFF : $urandom_range(0, 60));
			write_reg(REG_GAIN, (ph == 2) ? 255 : (ph == 3) ? 0 : $urandom_range(1, 3));
			write_reg(REG_OFFSET, (ph == 1) ? 255 : $urandom_range(0, 4));
			write_reg(REG_PAUSE, (ph == 0) ? 0 : (ph == 3) ? 15 : $urandom_range(1, 9));
			write_reg(REG_FLOOR, (ph == 2) ? 0 : (ph == 3) ? 32767 : $urandom_range(2400, 3000));
			for (int s = 0; s < 12; s++) run_session($urandom_range(8, 24));
			drain();
		end
		// wide cell spread with large gain
		write_reg(REG_RESTART, 0);
		write_reg(REG_GAIN, 255);
		write_reg(REG_OFFSET, 0);
		write_cell(10, 2600);
		write_cell(11, 32767);
		repeat (20) tick(0, 1);
		drain();

		if (board.errors == 0)
			$display("PASS cell_balancing_scheduler");
		else
			$display("FAIL cell_balancing_scheduler");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/cbs_pkg.sv
rtl/cbs_cell.sv
rtl/cell_balancing_scheduler.sv
rtl/cbs_checker.sv
sim/tb.sv
